/* rtl/tlr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thick line rasterizer package
// Shared constants, item kinds and the control structs passed between the
// front end and the pixel stepper.
// ----------------------------------------------------------------------------
package tlr_pkg;

	localparam int TLR_COORD_BITS  = 13;
	localparam int TLR_MAX_WIDTH   = 64;
	localparam int TLR_WIDTH_BITS  = 7;
	localparam int TLR_COLOR_BITS  = 24;
	localparam int TLR_QUEUE_DEPTH = 2;

	typedef enum logic {
		OP_START = 1'b0,
		OP_STEP  = 1'b1
	} tlr_op_t;

	typedef struct packed {
		logic is_start;
		logic x_neg;
		logic y_neg;
		logic shift_y;
	} tlr_cmd_t;

	typedef struct packed {
		logic active;
	} tlr_back_st_t;

	typedef struct packed {
		logic [1:0] level;
	} tlr_front_st_t;

endpackage

/* rtl/tlr_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thick line rasterizer front end
// Accepts items, sets up line parameters for start items and holds decoded
// items in a short queue ahead of the pixel stepper.
// ----------------------------------------------------------------------------
module tlr_front import tlr_pkg::*; #(
	parameter int COORD_BITS = TLR_COORD_BITS,
	parameter int MAX_WIDTH  = TLR_MAX_WIDTH,
	localparam int EW  = COORD_BITS + 3,
	localparam int PTW = $clog2(MAX_WIDTH + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  tlr_op_t                      in_op,
	input  logic signed [COORD_BITS-1:0] in_sx,
	input  logic signed [COORD_BITS-1:0] in_sy,
	input  logic signed [COORD_BITS-1:0] in_ex,
	input  logic signed [COORD_BITS-1:0] in_ey,
	input  logic [TLR_WIDTH_BITS-1:0]    in_width,
	input  logic [TLR_COLOR_BITS-1:0]    in_color,
	output logic                         q_valid,
	input  logic                         q_ready,
	output tlr_cmd_t                     q_cmd,
	output logic signed [COORD_BITS-1:0] q_org_x,
	output logic signed [COORD_BITS-1:0] q_org_y,
	output logic signed [COORD_BITS-1:0] q_tgt_x,
	output logic signed [COORD_BITS-1:0] q_tgt_y,
	output logic [COORD_BITS-1:0]        q_dx,
	output logic [COORD_BITS-1:0]        q_dy,
	output logic signed [EW-1:0]         q_err,
	output logic [PTW-1:0]               q_total,
	output logic [TLR_COLOR_BITS-1:0]    q_color,
	output tlr_front_st_t                status
);

	localparam int QAW = $clog2(TLR_QUEUE_DEPTH);
	localparam int QCW = $clog2(TLR_QUEUE_DEPTH + 1);

	logic signed [COORD_BITS:0]   diff_x, diff_y, abs_x, abs_y;
	logic [COORD_BITS-1:0]        dx, dy;
	logic signed [EW-1:0]         err0;
	logic [PTW-1:0]               total;
	tlr_cmd_t                     cmd;
	logic                         push, pop;

	tlr_cmd_t                     cmd_mem   [TLR_QUEUE_DEPTH];
	logic signed [COORD_BITS-1:0] ox_mem    [TLR_QUEUE_DEPTH];
	logic signed [COORD_BITS-1:0] oy_mem    [TLR_QUEUE_DEPTH];
	logic signed [COORD_BITS-1:0] tx_mem    [TLR_QUEUE_DEPTH];
	logic signed [COORD_BITS-1:0] ty_mem    [TLR_QUEUE_DEPTH];
	logic [COORD_BITS-1:0]        dx_mem    [TLR_QUEUE_DEPTH];
	logic [COORD_BITS-1:0]        dy_mem    [TLR_QUEUE_DEPTH];
	logic signed [EW-1:0]         err_mem   [TLR_QUEUE_DEPTH];
	logic [PTW-1:0]               total_mem [TLR_QUEUE_DEPTH];
	logic [TLR_COLOR_BITS-1:0]    color_mem [TLR_QUEUE_DEPTH];

	logic [QAW-1:0]               wr_ptr_q, rd_ptr_q;
	logic [QCW-1:0]               count_q;

	always_comb begin
		diff_x = (COORD_BITS+1)'(in_ex) - (COORD_BITS+1)'(in_sx);
		diff_y = (COORD_BITS+1)'(in_ey) - (COORD_BITS+1)'(in_sy);
		abs_x  = diff_x[COORD_BITS] ? -diff_x : diff_x;
		abs_y  = diff_y[COORD_BITS] ? -diff_y : diff_y;
		dx     = abs_x[COORD_BITS-1:0];
		dy     = abs_y[COORD_BITS-1:0];
		if (dx > dy) begin
			err0 = EW'($signed({1'b0, dx >> 1}));
		end else begin
			err0 = -EW'($signed({1'b0, dy >> 1}));
		end
		if (in_width == '0) begin
			total = PTW'(1);
		end else if (int'(in_width) > MAX_WIDTH) begin
			total = PTW'(MAX_WIDTH);
		end else begin
			total = PTW'(in_width);
		end
		cmd.is_start = (in_op == OP_START);
		cmd.x_neg    = diff_x[COORD_BITS] || (diff_x == '0);
		cmd.y_neg    = diff_y[COORD_BITS] || (diff_y == '0);
		cmd.shift_y  = dy > dx;
	end

	assign in_ready     = count_q != QCW'(TLR_QUEUE_DEPTH);
	assign q_valid      = count_q != '0;
	assign push         = in_valid && in_ready;
	assign pop          = q_valid && q_ready;
	assign status.level = 2'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			cmd_mem[wr_ptr_q]   <= cmd;
			ox_mem[wr_ptr_q]    <= in_sx;
			oy_mem[wr_ptr_q]    <= in_sy;
			tx_mem[wr_ptr_q]    <= in_ex;
			ty_mem[wr_ptr_q]    <= in_ey;
			dx_mem[wr_ptr_q]    <= dx;
			dy_mem[wr_ptr_q]    <= dy;
			err_mem[wr_ptr_q]   <= err0;
			total_mem[wr_ptr_q] <= total;
			color_mem[wr_ptr_q] <= in_color;
		end
	end

	assign q_cmd   = cmd_mem[rd_ptr_q];
	assign q_org_x = ox_mem[rd_ptr_q];
	assign q_org_y = oy_mem[rd_ptr_q];
	assign q_tgt_x = tx_mem[rd_ptr_q];
	assign q_tgt_y = ty_mem[rd_ptr_q];
	assign q_dx    = dx_mem[rd_ptr_q];
	assign q_dy    = dy_mem[rd_ptr_q];
	assign q_err   = err_mem[rd_ptr_q];
	assign q_total = total_mem[rd_ptr_q];
	assign q_color = color_mem[rd_ptr_q];

endmodule

/* rtl/tlr_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thick line rasterizer pixel stepper
// Holds the current line, walks it one pixel per step item with the
// Bresenham error term and drives the registered pixel output.
// ----------------------------------------------------------------------------
module tlr_back import tlr_pkg::*; #(
	parameter int COORD_BITS = TLR_COORD_BITS,
	parameter int MAX_WIDTH  = TLR_MAX_WIDTH,
	localparam int EW  = COORD_BITS + 3,
	localparam int PTW = $clog2(MAX_WIDTH + 1),
	localparam int OB  = COORD_BITS + 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	output logic                         q_ready,
	input  tlr_cmd_t                     q_cmd,
	input  logic signed [COORD_BITS-1:0] q_org_x,
	input  logic signed [COORD_BITS-1:0] q_org_y,
	input  logic signed [COORD_BITS-1:0] q_tgt_x,
	input  logic signed [COORD_BITS-1:0] q_tgt_y,
	input  logic [COORD_BITS-1:0]        q_dx,
	input  logic [COORD_BITS-1:0]        q_dy,
	input  logic signed [EW-1:0]         q_err,
	input  logic [PTW-1:0]               q_total,
	input  logic [TLR_COLOR_BITS-1:0]    q_color,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [OB-1:0]         out_x,
	output logic signed [OB-1:0]         out_y,
	output logic [TLR_COLOR_BITS-1:0]    out_color,
	output logic                         out_last,
	output tlr_back_st_t                 status
);

	localparam int PIW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int IW  = COORD_BITS + PIW + 1;

	logic                         active_q, out_valid_q;
	logic signed [COORD_BITS-1:0] org_x_q, org_y_q;
	logic signed [IW-1:0]         end_x_q, end_y_q, cur_x_q, cur_y_q;
	logic [COORD_BITS-1:0]        dx_q, dy_q;
	logic                         x_neg_q, y_neg_q, shift_y_q;
	logic signed [EW-1:0]         err_q, err0_q;
	logic [PIW-1:0]               idx_q;
	logic [PTW-1:0]               total_q;
	logic [TLR_COLOR_BITS-1:0]    color_q;
	logic signed [OB-1:0]         out_x_q, out_y_q;
	logic [TLR_COLOR_BITS-1:0]    out_color_q;
	logic                         out_last_q;

	logic                         take, do_start, do_pixel;
	logic                         at_end, more;
	logic [PIW-1:0]               nidx;
	logic signed [IW-1:0]         shift_n;
	logic signed [EW-1:0]         dxs, dys, err_next;
	logic                         move_x, move_y;

	assign q_ready  = !out_valid_q || out_ready;
	assign take     = q_valid && q_ready;
	assign do_start = take && q_cmd.is_start;
	assign do_pixel = take && !q_cmd.is_start && active_q;

	always_comb begin
		at_end   = (cur_x_q == end_x_q) && (cur_y_q == end_y_q);
		more     = (int'(idx_q) + 1) < int'(total_q);
		nidx     = idx_q + PIW'(1);
		shift_n  = IW'($signed({1'b0, nidx}));
		dxs      = EW'($signed({1'b0, dx_q}));
		dys      = EW'($signed({1'b0, dy_q}));
		move_x   = err_q > -dxs;
		move_y   = err_q < dys;
		err_next = err_q;
		if (move_x) begin
			err_next = err_next - dys;
		end
		if (move_y) begin
			err_next = err_next + dxs;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_start) begin
				active_q <= 1'b1;
			end else if (do_pixel && at_end && !more) begin
				active_q <= 1'b0;
			end
			if (do_pixel) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_start) begin
			org_x_q   <= q_org_x;
			org_y_q   <= q_org_y;
			end_x_q   <= IW'(q_tgt_x);
			end_y_q   <= IW'(q_tgt_y);
			cur_x_q   <= IW'(q_org_x);
			cur_y_q   <= IW'(q_org_y);
			dx_q      <= q_dx;
			dy_q      <= q_dy;
			x_neg_q   <= q_cmd.x_neg;
			y_neg_q   <= q_cmd.y_neg;
			shift_y_q <= q_cmd.shift_y;
			err_q     <= q_err;
			err0_q    <= q_err;
			idx_q     <= '0;
			total_q   <= q_total;
			color_q   <= q_color;
		end else if (do_pixel) begin
			out_x_q     <= cur_x_q[OB-1:0];
			out_y_q     <= cur_y_q[OB-1:0];
			out_color_q <= color_q;
			out_last_q  <= at_end && !more;
			if (at_end) begin
				if (more) begin
					idx_q <= nidx;
					err_q <= err0_q;
					if (shift_y_q) begin
						cur_x_q <= IW'(org_x_q);
						cur_y_q <= IW'(org_y_q) + shift_n;
						end_y_q <= end_y_q + IW'(1);
					end else begin
						cur_x_q <= IW'(org_x_q) + shift_n;
						cur_y_q <= IW'(org_y_q);
						end_x_q <= end_x_q + IW'(1);
					end
				end
			end else begin
				err_q <= err_next;
				if (move_x) begin
					cur_x_q <= x_neg_q ? cur_x_q - IW'(1) : cur_x_q + IW'(1);
				end
				if (move_y) begin
					cur_y_q <= y_neg_q ? cur_y_q - IW'(1) : cur_y_q + IW'(1);
				end
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign out_x         = out_x_q;
	assign out_y         = out_y_q;
	assign out_color     = out_color_q;
	assign out_last      = out_last_q;
	assign status.active = active_q;

endmodule

/* rtl/thick_line_rasterizer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thick line rasterizer
// Bresenham line drawing with a width given as a number of parallel passes.
//
// Channel   Dir  Handshake              Contents
// s_axis    in   tvalid/tready          start (tuser 0) or step (tuser 1) item
// m_axis    out  tvalid/tready, tlast   one pixel, tlast on the final pixel
//
// The stepper takes one item per clock while its output is free or drained;
// start items and step items with no active line produce no transaction.
// The front end sets up a start item combinationally into a two-entry queue.
// Reset clears the queue, the output valid flag and the line-active flag.
// The stepper only advances while its output register is free or drained.
// ----------------------------------------------------------------------------
module thick_line_rasterizer import tlr_pkg::*; #(
	parameter int COORD_BITS = TLR_COORD_BITS,
	parameter int MAX_WIDTH  = TLR_MAX_WIDTH,
	localparam int IDW = 4 * COORD_BITS + TLR_WIDTH_BITS + TLR_COLOR_BITS,
	localparam int ITW = ((IDW + 7) / 8) * 8,
	localparam int ODW = 2 * (COORD_BITS + 1) + TLR_COLOR_BITS,
	localparam int OTW = ((ODW + 7) / 8) * 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_axis_tvalid,
	output logic           s_axis_tready,
	// start_x, start_y, end_x, end_y, line_width, line_color, zero fill
	input  logic [ITW-1:0] s_axis_tdata,
	// op
	input  logic           s_axis_tuser,
	output logic           m_axis_tvalid,
	input  logic           m_axis_tready,
	// pixel_x, pixel_y, pixel_color, zero fill
	output logic [OTW-1:0] m_axis_tdata,
	output logic           m_axis_tlast
);

	localparam int EW  = COORD_BITS + 3;
	localparam int PTW = $clog2(MAX_WIDTH + 1);
	localparam int OB  = COORD_BITS + 1;
	localparam int C   = COORD_BITS;
	localparam int WO  = 4 * C;
	localparam int CO  = WO + TLR_WIDTH_BITS;

	tlr_cmd_t                  q_cmd;
	logic                      q_valid, q_ready;
	logic signed [C-1:0]       q_org_x, q_org_y, q_tgt_x, q_tgt_y;
	logic [C-1:0]              q_dx, q_dy;
	logic signed [EW-1:0]      q_err;
	logic [PTW-1:0]            q_total;
	logic [TLR_COLOR_BITS-1:0] q_color;
	logic signed [OB-1:0]      px, py;
	logic [TLR_COLOR_BITS-1:0] pcolor;
	tlr_back_st_t              back_st;
	tlr_front_st_t             front_st;

	tlr_front #(
		.COORD_BITS(COORD_BITS),
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_op   (tlr_op_t'(s_axis_tuser)),
		.in_sx   ($signed(s_axis_tdata[C-1:0])),
		.in_sy   ($signed(s_axis_tdata[2*C-1:C])),
		.in_ex   ($signed(s_axis_tdata[3*C-1:2*C])),
		.in_ey   ($signed(s_axis_tdata[4*C-1:3*C])),
		.in_width(s_axis_tdata[CO-1:WO]),
		.in_color(s_axis_tdata[CO+TLR_COLOR_BITS-1:CO]),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_cmd   (q_cmd),
		.q_org_x (q_org_x),
		.q_org_y (q_org_y),
		.q_tgt_x (q_tgt_x),
		.q_tgt_y (q_tgt_y),
		.q_dx    (q_dx),
		.q_dy    (q_dy),
		.q_err   (q_err),
		.q_total (q_total),
		.q_color (q_color),
		.status  (front_st)
	);

	tlr_back #(
		.COORD_BITS(COORD_BITS),
		.MAX_WIDTH (MAX_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_cmd    (q_cmd),
		.q_org_x  (q_org_x),
		.q_org_y  (q_org_y),
		.q_tgt_x  (q_tgt_x),
		.q_tgt_y  (q_tgt_y),
		.q_dx     (q_dx),
		.q_dy     (q_dy),
		.q_err    (q_err),
		.q_total  (q_total),
		.q_color  (q_color),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_x    (px),
		.out_y    (py),
		.out_color(pcolor),
		.out_last (m_axis_tlast),
		.status   (back_st)
	);

	assign m_axis_tdata = OTW'({pcolor, py, px});

	a_take_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && q_ready) |-> (!m_axis_tvalid || m_axis_tready))
		else $error("Stepper took a queue item while the output was stalled.");

	a_last_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> !back_st.active)
		else $error("Line still active while its final pixel is presented.");

	a_push_reaches_queue: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> (q_valid && front_st.level != 2'd0))
		else $error("Accepted transaction did not reach the queue.");

endmodule

/* tb/sv/tb_thick_line_rasterizer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thick line rasterizer testbench
// Drives start and step transactions into the rasterizer and checks every
// emitted pixel against a cycle-free model of the Bresenham stepper with
// parallel passes. Directed tests cover idle steps, single-point lines,
// shallow, steep and diagonal lines, extreme endpoints and aborted lines.
// A long random stream follows, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_thick_line_rasterizer;
	import tlr_pkg::*;

	localparam int CB     = TLR_COORD_BITS;
	localparam int OB     = TLR_COORD_BITS + 1;
	localparam int IDW    = 4 * CB + TLR_WIDTH_BITS + TLR_COLOR_BITS;
	localparam int ITW    = ((IDW + 7) / 8) * 8;
	localparam int ODW    = 2 * OB + TLR_COLOR_BITS;
	localparam int OTW    = ((ODW + 7) / 8) * 8;
	localparam int SX_LSB = 0;
	localparam int SY_LSB = CB;
	localparam int EX_LSB = 2 * CB;
	localparam int EY_LSB = 3 * CB;
	localparam int W_LSB  = 4 * CB;
	localparam int C_LSB  = 4 * CB + TLR_WIDTH_BITS;
	localparam int PY_LSB = OB;
	localparam int PC_LSB = 2 * OB;
	localparam int COORD_MAX = (1 << (CB - 1)) - 1;
	localparam int COORD_MIN = -(1 << (CB - 1));
	localparam int RANDOM_ITEMS = 900;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct {
		logic [OB-1:0]             x;
		logic [OB-1:0]             y;
		logic [TLR_COLOR_BITS-1:0] color;
		logic                      last;
	} raster_pixel_t;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           s_axis_tvalid = 1'b0;
	logic           s_axis_tready;
	logic [ITW-1:0] s_axis_tdata = '0;
	logic           s_axis_tuser = 1'b0;
	logic           m_axis_tvalid;
	logic           m_axis_tready = 1'b0;
	logic [OTW-1:0] m_axis_tdata;
	logic           m_axis_tlast;

	raster_pixel_t pending_pixels[$];
	raster_pixel_t next_pixel;
	int            errors = 0;
	int            cycle_count = 0;
	int            useful_items = 0;
	bit            steady = 1'b0;

	bit                        line_busy = 1'b0;
	int                        org_x = 0, org_y = 0, tgt_x = 0, tgt_y = 0;
	int                        pos_x = 0, pos_y = 0, span_x = 0, span_y = 0;
	bit                        neg_x = 1'b0, neg_y = 1'b0;
	int                        err_acc = 0;
	int                        pass_no = 0, pass_cnt = 1;
	logic [TLR_COLOR_BITS-1:0] line_rgb = '0;

	thick_line_rasterizer u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("thick_line_rasterizer: mismatch");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_axis_tready <= steady || ($urandom_range(99) >= 8);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_pixels.size() == 0) begin
				$error("unexpected pixel transaction: tdata %h tlast %b",
					m_axis_tdata, m_axis_tlast);
				errors++;
			end else begin
				next_pixel = pending_pixels.pop_front();
				if (m_axis_tdata[0 +: OB] !== next_pixel.x) begin
					$error("pixel_x expected %h actual %h", next_pixel.x,
						m_axis_tdata[0 +: OB]);
					errors++;
				end
				if (m_axis_tdata[PY_LSB +: OB] !== next_pixel.y) begin
					$error("pixel_y expected %h actual %h", next_pixel.y,
						m_axis_tdata[PY_LSB +: OB]);
					errors++;
				end
				if (m_axis_tdata[PC_LSB +: TLR_COLOR_BITS] !== next_pixel.color) begin
					$error("pixel_color expected %h actual %h", next_pixel.color,
						m_axis_tdata[PC_LSB +: TLR_COLOR_BITS]);
					errors++;
				end
				if (m_axis_tdata[OTW-1:ODW] !== '0) begin
					$error("zero fill expected 0 actual %h", m_axis_tdata[OTW-1:ODW]);
					errors++;
				end
				if (m_axis_tlast !== next_pixel.last) begin
					$error("last_pixel expected %b actual %b", next_pixel.last,
						m_axis_tlast);
					errors++;
				end
			end
		end
	end

	task automatic restart_pass();
		pos_x = org_x;
		pos_y = org_y;
		if (span_y > span_x)
			pos_y += pass_no;
		else
			pos_x += pass_no;
		err_acc = (span_x > span_y) ? span_x / 2 : -(span_y / 2);
	endtask

	task automatic rasterize_item(input tlr_op_t op, input logic [ITW-1:0] data);
		raster_pixel_t px;
		int            goal_x;
		int            goal_y;
		int            e2;
		int            w;
		if (op == OP_START) begin
			org_x = int'($signed(data[SX_LSB +: CB]));
			org_y = int'($signed(data[SY_LSB +: CB]));
			tgt_x = int'($signed(data[EX_LSB +: CB]));
			tgt_y = int'($signed(data[EY_LSB +: CB]));
			span_x = (tgt_x > org_x) ? tgt_x - org_x : org_x - tgt_x;
			span_y = (tgt_y > org_y) ? tgt_y - org_y : org_y - tgt_y;
			neg_x = !(org_x < tgt_x);
			neg_y = !(org_y < tgt_y);
			w = int'(data[W_LSB +: TLR_WIDTH_BITS]);
			if (w == 0)
				w = 1;
			if (w > TLR_MAX_WIDTH)
				w = TLR_MAX_WIDTH;
			pass_cnt = w;
			pass_no = 0;
			line_rgb = data[C_LSB +: TLR_COLOR_BITS];
			restart_pass();
			line_busy = 1'b1;
		end else if (line_busy) begin
			goal_x = tgt_x;
			goal_y = tgt_y;
			if (span_y > span_x)
				goal_y += pass_no;
			else
				goal_x += pass_no;
			px.x = pos_x[OB-1:0];
			px.y = pos_y[OB-1:0];
			px.color = line_rgb;
			px.last = 1'b0;
			if (pos_x == goal_x && pos_y == goal_y) begin
				if (pass_no + 1 < pass_cnt) begin
					pass_no++;
					restart_pass();
				end else begin
					px.last = 1'b1;
					line_busy = 1'b0;
				end
			end else begin
				e2 = err_acc;
				if (e2 > -span_x) begin
					err_acc -= span_y;
					pos_x += neg_x ? -1 : 1;
				end
				if (e2 < span_y) begin
					err_acc += span_x;
					pos_y += neg_y ? -1 : 1;
				end
			end
			pending_pixels.push_back(px);
		end
	endtask

	task automatic push_item(input tlr_op_t op, input logic [ITW-1:0] data);
		if (!steady && $urandom_range(99) < 3) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= data;
		do @(posedge clk); while (!s_axis_tready);
		if (op == OP_START || line_busy)
			useful_items++;
		rasterize_item(op, data);
	endtask

	function automatic logic [ITW-1:0] noise_data();
		logic [95:0] r;
		r = {$urandom, $urandom, $urandom};
		return {{(ITW - IDW){1'b0}}, r[IDW-1:0]};
	endfunction

	function automatic logic [ITW-1:0] pack_line(input int sx, input int sy, input int ex,
		input int ey, input int w, input logic [TLR_COLOR_BITS-1:0] rgb);
		logic [ITW-1:0] d;
		d = '0;
		d[SX_LSB +: CB] = sx[CB-1:0];
		d[SY_LSB +: CB] = sy[CB-1:0];
		d[EX_LSB +: CB] = ex[CB-1:0];
		d[EY_LSB +: CB] = ey[CB-1:0];
		d[W_LSB +: TLR_WIDTH_BITS] = w[TLR_WIDTH_BITS-1:0];
		d[C_LSB +: TLR_COLOR_BITS] = rgb;
		return d;
	endfunction

	function automatic int full_coord();
		logic signed [CB-1:0] r;
		r = CB'($urandom);
		return int'(r);
	endfunction

	function automatic int near_coord(input int base, input int reach);
		int o;
		int v;
		o = $urandom_range(0, 2 * reach) - reach;
		v = base + o;
		if (v > COORD_MAX || v < COORD_MIN)
			v = base - o;
		return v;
	endfunction

	task automatic step_n(input int n);
		repeat (n) push_item(OP_STEP, noise_data());
	endtask

	task automatic render_line(input int sx, input int sy, input int ex, input int ey,
		input int w, input logic [TLR_COLOR_BITS-1:0] rgb);
		push_item(OP_START, pack_line(sx, sy, ex, ey, w, rgb));
		while (line_busy)
			push_item(OP_STEP, noise_data());
	endtask

	task automatic test_idle_step();
		push_item(OP_STEP, '0);
		push_item(OP_STEP, {{(ITW - IDW){1'b0}}, {IDW{1'b1}}});
	endtask

	task automatic test_single_point();
		render_line(5, -5, 5, -5, 0, 24'h123456);
		step_n(1);
	endtask

	task automatic test_shallow_line();
		render_line(COORD_MIN, 0, COORD_MIN + 3, 1, 1, 24'hFF0000);
	endtask

	task automatic test_steep_line();
		render_line(10, 10, 9, 8, 2, 24'h00FF00);
	endtask

	task automatic test_abort_extremes();
		push_item(OP_START, pack_line(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 127,
			24'hFFFFFF));
		step_n(3);
		push_item(OP_START, pack_line(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 64,
			24'h000000));
		step_n(2);
		render_line(-1, COORD_MAX, 1, COORD_MAX - 2, 1, 24'hA5A5A5);
	endtask

	task automatic test_random_stream();
		int base_count;
		int pick;
		int sx;
		int sy;
		base_count = useful_items;
		while (useful_items - base_count < RANDOM_ITEMS) begin
			steady = (useful_items - base_count >= 350) && (useful_items - base_count < 550);
			pick = $urandom_range(99);
			sx = full_coord();
			sy = full_coord();
			if (pick < 72) begin
				render_line(sx, sy, near_coord(sx, 8), near_coord(sy, 8),
					$urandom_range(1, 4), TLR_COLOR_BITS'($urandom));
			end else if (pick < 84) begin
				render_line(sx, sy, near_coord(sx, 2), near_coord(sy, 2),
					$urandom_range(0, 127), TLR_COLOR_BITS'($urandom));
			end else if (pick < 87) begin
				render_line(sx, sy, near_coord(sx, 200), near_coord(sy, 200),
					$urandom_range(1, 2), TLR_COLOR_BITS'($urandom));
			end else if (pick < 96) begin
				push_item(OP_START, pack_line(sx, sy, full_coord(), full_coord(),
					$urandom_range(0, 127), TLR_COLOR_BITS'($urandom)));
				step_n($urandom_range(0, 6));
			end else begin
				step_n($urandom_range(1, 3));
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_step();
		test_single_point();
		test_shallow_line();
		test_steep_line();
		test_abort_extremes();
		test_random_stream();
		s_axis_tvalid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0 && pending_pixels.size() == 0)
			$display("thick_line_rasterizer: match");
		else
			$display("thick_line_rasterizer: mismatch");
		$finish;
	end

endmodule

/* sim.f */
rtl/tlr_pkg.sv
rtl/tlr_front.sv
rtl/tlr_back.sv
rtl/thick_line_rasterizer.sv
tb/sv/tb_thick_line_rasterizer.sv
